### hdl/rcf_pkg.sv
// shared types, constants and crc helpers for the settings record crc framer
// no dependencies; used by the builder, the serialiser and the top level
package rcf_pkg;

    localparam int RecLen = 12;
    localparam int IdxW = $clog2(RecLen);
    localparam logic [IdxW-1:0] LAST_IDX = IdxW'(RecLen - 1);

    localparam logic [7:0] MAGIC_0 = 8'h52;
    localparam logic [7:0] MAGIC_1 = 8'h59;
    localparam logic [7:0] MAGIC_2 = 8'h5A;
    localparam logic [7:0] MAGIC_3 = 8'h44;
    localparam logic [7:0] VERSION = 8'h01;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic [7:0] rotation;
        logic [7:0] sleep_sel;
        logic [7:0] brightness;
    } tuple_t;

    // byte k of the record sits at index k
    typedef logic [RecLen-1:0][7:0] record_t;

    typedef struct packed {
        logic    valid;
        record_t data;
    } rec_link_t;

    // one byte through the reflected crc-32
    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] a;
        a = acc ^ {24'b0, d};
        for (int b = 0; b < 8; b++)
        begin
            a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
        end
        return a;
    endfunction

    // crc of the record body with all three setting bytes zero
    function automatic logic [31:0] crc_base();
        logic [31:0] a;
        a = CRC_INIT;
        a = crc_byte(a, MAGIC_0);
        a = crc_byte(a, MAGIC_1);
        a = crc_byte(a, MAGIC_2);
        a = crc_byte(a, MAGIC_3);
        a = crc_byte(a, VERSION);
        a = crc_byte(a, 8'h00);
        a = crc_byte(a, 8'h00);
        a = crc_byte(a, 8'h00);
        return ~a;
    endfunction

    // contribution of each setting bit, rotation bits first, lsb first
    function automatic logic [23:0][31:0] crc_cols();
        logic [23:0][31:0] cols;
        logic [31:0]       a;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                a = '0;
                for (int m = 0; m < 3; m++)
                begin
                    a = crc_byte(a, (m == k) ? 8'(1 << i) : 8'h00);
                end
                cols[k*8 + i] = a;
            end
        end
        return cols;
    endfunction

    localparam logic [31:0]       CRC_BASE = crc_base();
    localparam logic [23:0][31:0] CRC_COLS = crc_cols();

endpackage

### hdl/rcf_if.sv
// handshake channels of the settings record crc framer
// does not use rcf_pkg; its widths are kept in step with it
interface rcf_settings_if;
    logic       valid;
    logic       ready;
    logic [7:0] rotation;
    logic [7:0] sleep_sel;
    logic [7:0] brightness;

    modport source (output valid, output rotation, output sleep_sel, output brightness,
                    input ready);
    modport sink   (input valid, input rotation, input sleep_sel, input brightness,
                    output ready);
endinterface

interface rcf_record_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### hdl/rcf_builder.sv
// input register for one settings item and the record builder with its crc trailer
// depends on rcf_pkg and rcf_settings_if
module rcf_builder (
    input  logic                  clk,
    input  logic                  rst_n,
    rcf_settings_if.sink          settings,
    output rcf_pkg::rec_link_t    rec,
    input  logic                  rec_ready
);

    logic              valid_reg;
    rcf_pkg::tuple_t   tuple_reg;
    logic [23:0]       bits;
    logic [31:0]       crc;
    logic              accept;

    assign settings.ready = !valid_reg || rec_ready;
    assign accept = settings.valid && settings.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (rec_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tuple_reg.rotation   <= settings.rotation;
            tuple_reg.sleep_sel  <= settings.sleep_sel;
            tuple_reg.brightness <= settings.brightness;
        end
    end

    // crc is linear in the setting bits
    assign bits = {tuple_reg.brightness, tuple_reg.sleep_sel, tuple_reg.rotation};

    always_comb
    begin
        crc = rcf_pkg::CRC_BASE;
        for (int j = 0; j < 24; j++)
        begin
            if (bits[j])
            begin
                crc = crc ^ rcf_pkg::CRC_COLS[j];
            end
        end
    end

    always_comb
    begin
        rec.valid    = valid_reg;
        rec.data[0]  = rcf_pkg::MAGIC_0;
        rec.data[1]  = rcf_pkg::MAGIC_1;
        rec.data[2]  = rcf_pkg::MAGIC_2;
        rec.data[3]  = rcf_pkg::MAGIC_3;
        rec.data[4]  = rcf_pkg::VERSION;
        rec.data[5]  = tuple_reg.rotation;
        rec.data[6]  = tuple_reg.sleep_sel;
        rec.data[7]  = tuple_reg.brightness;
        rec.data[8]  = crc[31:24];
        rec.data[9]  = crc[23:16];
        rec.data[10] = crc[15:8];
        rec.data[11] = crc[7:0];
    end

endmodule

### hdl/rcf_serialiser.sv
// record register and byte serialiser driving the result channel
// depends on rcf_pkg and rcf_record_if
module rcf_serialiser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcf_pkg::rec_link_t    rec,
    output logic                  rec_ready,
    rcf_record_if.source          record
);

    logic                        busy_reg;
    logic [rcf_pkg::IdxW-1:0]    idx_reg;
    rcf_pkg::record_t            rec_reg;
    logic                        at_last;
    logic                        load;

    assign at_last   = (idx_reg == rcf_pkg::LAST_IDX);
    assign rec_ready = !busy_reg || (record.ready && at_last);
    assign load      = rec.valid && rec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && record.ready)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec.data;
        end
    end

    assign record.valid    = busy_reg;
    assign record.out_byte = rec_reg[idx_reg];
    assign record.last     = at_last;

endmodule

### hdl/settings_record_crc_framer.sv
// top level of the settings record crc framer
// depends on rcf_pkg, rcf_if, rcf_builder and rcf_serialiser
//
// each settings item becomes a 12-byte record sent one byte per cycle while ready is high:
// four magic bytes, a version byte of 1, rotation, sleep index, brightness, then the reflected
// crc-32 over the first eight bytes, most significant byte first, with last set on the twelfth
// byte. the crc is formed combinationally from the input register, and the next item is taken
// and held while the current record drains, so records follow each other with no gap. nothing
// is kept between items
module settings_record_crc_framer (
    input  logic          clk,
    input  logic          rst_n,
    rcf_settings_if.sink  settings,
    rcf_record_if.source  record
);

    rcf_pkg::rec_link_t rec;
    logic               rec_ready;

    rcf_builder u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .settings  (settings),
        .rec       (rec),
        .rec_ready (rec_ready)
    );

    rcf_serialiser u_serialiser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rec),
        .rec_ready (rec_ready),
        .record    (record)
    );

endmodule
